@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/gedc_pkg.sv @@
// Package: constants and CORDIC angle table for the gamepad drive command unit.
// No dependencies.
package gedc_pkg;
    localparam int AXIS_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_W = 27;
    localparam logic [1:0] KIND_BALL_MOVE = 2'd0;
    localparam logic [1:0] KIND_BALL_ROT = 2'd1;
    localparam logic [1:0] KIND_HEAD_SPEED = 2'd2;
    localparam logic [1:0] KIND_HEAD_ROT = 2'd3;
    localparam logic [7:0] CMD_BUTTON = 8'd1;
    localparam logic [7:0] CMD_AXIS = 8'd2;
    localparam logic [2:0] REG_BALL_GAIN = 3'd0;
    localparam logic [2:0] REG_HEAD_GAIN = 3'd1;
    localparam logic [2:0] REG_BUTTON_GAIN = 3'd2;
    localparam logic [2:0] REG_BUTTON_MAP = 3'd3;
    localparam logic [2:0] REG_AXIS_MAP = 3'd4;

    function automatic logic [ANG_W-1:0] atan_deg(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0: r = 27'd2949120;
            5'd1: r = 27'd1740967;
            5'd2: r = 27'd919879;
            5'd3: r = 27'd466945;
            5'd4: r = 27'd234379;
            5'd5: r = 27'd117304;
            5'd6: r = 27'd58666;
            5'd7: r = 27'd29335;
            5'd8: r = 27'd14668;
            5'd9: r = 27'd7334;
            5'd10: r = 27'd3667;
            5'd11: r = 27'd1833;
            5'd12: r = 27'd917;
            5'd13: r = 27'd458;
            5'd14: r = 27'd229;
            5'd15: r = 27'd115;
            5'd16: r = 27'd57;
            5'd17: r = 27'd29;
            5'd18: r = 27'd14;
            5'd19: r = 27'd7;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

@@ design/gedc_stick_unit.sv @@
// Left-stick unit: digit-serial square root (one result bit per cycle)
// and a CORDIC vectoring loop (one step per cycle). Uses gedc_pkg.
module gedc_stick_unit import gedc_pkg::*; #(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [AXIS_BITS-1:0] x,
    input  logic signed [AXIS_BITS-1:0] y,
    input  logic [19:0]                 gain,
    output logic                        done,
    output logic [19:0]                 speed,
    output logic [19:0]                 direction
);
    localparam int SQ_W = 2 * AXIS_BITS + 18;
    localparam int RT_W = AXIS_BITS + 9;
    localparam int CW = AXIS_BITS + 18;
    localparam int CNT_W = 6;
    localparam int SQ_STEPS = RT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_MUL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0] rad_reg, rad_next;
    logic [RT_W+1:0] rem_reg, rem_next;
    logic [RT_W-1:0] root_reg, root_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic xzero_reg, xzero_next, yneg_reg, yneg_next;
    logic [19:0] speed_reg, speed_next, dir_reg, dir_next;

    logic [RT_W+1:0] trial;
    logic signed [CW-1:0] dx, dy;
    logic [4:0] step;
    logic [RT_W+19:0] prod;
    logic signed [ANG_W+1:0] theta;
    logic signed [2*AXIS_BITS:0] xx, yy;

    assign done = (state_reg == ST_DONE);
    assign speed = speed_reg;
    assign direction = dir_reg;
    assign trial = {rem_reg[RT_W-1:0], rad_reg[SQ_W-1 -: 2]} - {root_reg, 2'b01};
    assign step = cnt_reg[4:0];
    assign dx = cy_reg >>> step;
    assign dy = cx_reg >>> step;
    assign prod = root_reg * gain;
    assign theta = (ANG_W+2)'(signed'(28'd180 << 16)) - (ANG_W+2)'(z_reg);
    assign xx = x * x;
    assign yy = y * y;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next = z_reg;
        xzero_next = xzero_reg;
        yneg_next = yneg_reg;
        speed_next = speed_reg;
        dir_next = dir_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    cnt_next = '0;
                    rad_next = {SQ_W'(xx) + SQ_W'(yy)} << 16;
                    rem_next = '0;
                    root_next = '0;
                    xzero_next = (x == '0);
                    yneg_next = y[AXIS_BITS-1];
                    if (!y[AXIS_BITS-1])
                    begin
                        cx_next = CW'(y) <<< 14;
                        cy_next = CW'(x) <<< 14;
                        z_next = '0;
                    end
                    else if (!x[AXIS_BITS-1])
                    begin
                        cx_next = CW'(x) <<< 14;
                        cy_next = -(CW'(y) <<< 14);
                        z_next = ANG_W'(90 << 16);
                    end
                    else
                    begin
                        cx_next = -(CW'(x) <<< 14);
                        cy_next = CW'(y) <<< 14;
                        z_next = -ANG_W'(90 << 16);
                    end
                end
            end
            ST_RUN:
            begin
                rad_next = rad_reg << 2;
                if (!trial[RT_W+1])
                begin
                    rem_next = trial;
                    root_next = {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[RT_W-1:0], rad_reg[SQ_W-1 -: 2]};
                    root_next = {root_reg[RT_W-2:0], 1'b0};
                end
                if (cnt_reg < CNT_W'(CORDIC_STEPS))
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next = cx_reg + dx;
                        cy_next = cy_reg - dy;
                        z_next = z_reg + signed'(atan_deg(step));
                    end
                    else
                    begin
                        cx_next = cx_reg - dx;
                        cy_next = cy_reg + dy;
                        z_next = z_reg - signed'(atan_deg(step));
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                speed_next = (prod[RT_W+19:24] > 400) ? 20'd400 : 20'(prod[RT_W+19:24]);
                if (xzero_reg)
                    dir_next = yneg_reg ? 20'd0 : 20'd180;
                else if (theta < 0)
                    dir_next = 20'd0;
                else if (theta > (ANG_W+2)'((360 << 16) - 1))
                    dir_next = 20'd359;
                else
                    dir_next = 20'(theta >>> 16);
                state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg <= z_next;
        xzero_reg <= xzero_next;
        yneg_reg <= yneg_next;
        speed_reg <= speed_next;
        dir_reg <= dir_next;
    end
endmodule

@@ design/gamepad_event_to_drive_commands_unit.sv @@
// Gamepad event to drive commands: top level.
// Button events give a registered result on acceptance; right-stick events pass through head
// phases 0 to 2; left-stick events wait for the stick unit. One transaction at a time; the left-stick
// cost is set by the serial square root, one root bit per cycle, with the CORDIC run alongside it.
// Reset: rst_n asynchronous active low clears configuration registers, axes, buttons and control.
// Depends on gedc_pkg, gedc_stick_unit, assert_macros.svh.
`include "assert_macros.svh"
module gamepad_event_to_drive_commands_unit import gedc_pkg::*; #(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         command,
    input  logic [7:0]         event_number,
    input  logic signed [15:0] event_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic signed [19:0] value_a,
    output logic signed [19:0] value_b
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_STICK = 2'd2;

    logic [19:0] ball_gain_reg, head_gain_reg;
    logic signed [15:0] button_gain_reg;
    logic [31:0] button_map_reg, axis_map_reg;
    logic signed [AXIS_BITS-1:0] axes_reg [4];
    logic [3:0] btn_reg;
    logic [1:0] state_reg;
    logic busy_hold_reg;
    logic out_valid_reg;
    logic [1:0] kind_reg;
    logic signed [19:0] a_reg, b_reg;
    logic signed [AXIS_BITS+20:0] hp_reg;
    logic [1:0] hphase_reg;
    logic signed [19:0] hx_reg;

    logic accept;
    logic [1:0] slot;
    logic hit;
    logic [31:0] map;
    logic signed [AXIS_BITS-1:0] axv;
    logic [3:0] btn_new;
    logic signed [17:0] rot;
    logic signed [AXIS_BITS+20:0] hprod;
    logic signed [AXIS_BITS+20:0] hq;
    logic signed [19:0] hsat;
    logic stick_start, stick_done;
    logic [19:0] stick_speed, stick_dir;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg && !busy_hold_reg;
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign result_kind = kind_reg;
    assign value_a = a_reg;
    assign value_b = b_reg;
    assign axv = event_value[AXIS_BITS-1:0];
    assign map = (command == CMD_BUTTON) ? button_map_reg : axis_map_reg;

    always_comb
    begin
        hit = 1'b1;
        slot = 2'd0;
        if (map[7:0] == event_number) slot = 2'd0;
        else if (map[15:8] == event_number) slot = 2'd1;
        else if (map[23:16] == event_number) slot = 2'd2;
        else if (map[31:24] == event_number) slot = 2'd3;
        else hit = 1'b0;
        btn_new = btn_reg;
        btn_new[slot] = (event_value != 16'sd0);
        if (slot[1])
            rot = (18'(btn_new[3]) - 18'(btn_new[2])) * 18'(button_gain_reg);
        else
            rot = (18'(btn_new[1]) - 18'(btn_new[0])) * 18'(button_gain_reg);
    end

    // phase 0 multiplies the x axis, later phases the y axis
    assign hprod = ((hphase_reg != 2'd0) ? (AXIS_BITS+21)'(axes_reg[3])
                                         : (AXIS_BITS+21)'(axes_reg[2]))
        * signed'({1'b0, head_gain_reg});
    assign hq = hp_reg[AXIS_BITS+20] ? -((-hp_reg) >>> 16) : (hp_reg >>> 16);
    assign hsat = (hq > 50) ? 20'sd50 : 20'(hq);
    assign stick_start = accept && (command == CMD_AXIS) && hit && !slot[1];

    gedc_stick_unit #(.AXIS_BITS(AXIS_BITS)) u_stick (
        .clk(clk), .rst_n(rst_n), .start(stick_start),
        .x(slot == 2'd0 ? axv : axes_reg[0]),
        .y(slot == 2'd1 ? axv : axes_reg[1]),
        .gain(ball_gain_reg), .done(stick_done),
        .speed(stick_speed), .direction(stick_dir)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ball_gain_reg <= '0;
            head_gain_reg <= '0;
            button_gain_reg <= '0;
            button_map_reg <= '0;
            axis_map_reg <= '0;
            for (int i = 0; i < 4; i++) axes_reg[i] <= '0;
            btn_reg <= '0;
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            busy_hold_reg <= 1'b0;
            hphase_reg <= 2'd0;
        end
        else
        begin
            busy_hold_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BALL_GAIN: ball_gain_reg <= cfg_data[19:0];
                    REG_HEAD_GAIN: head_gain_reg <= cfg_data[19:0];
                    REG_BUTTON_GAIN: button_gain_reg <= cfg_data[15:0];
                    REG_BUTTON_MAP: button_map_reg <= cfg_data;
                    REG_AXIS_MAP: axis_map_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (accept && hit && command == CMD_BUTTON)
            begin
                btn_reg <= btn_new;
                out_valid_reg <= 1'b1;
                kind_reg <= slot[1] ? KIND_HEAD_ROT : KIND_BALL_ROT;
                a_reg <= (slot[1] && rot > 45) ? 20'sd45 : 20'(rot);
                b_reg <= '0;
            end
            if (accept && hit && command == CMD_AXIS)
            begin
                axes_reg[slot] <= axv;
                state_reg <= slot[1] ? ST_HEAD : ST_STICK;
                hphase_reg <= 2'd0;
            end
            unique case (state_reg)
                ST_HEAD:
                begin
                    hphase_reg <= hphase_reg + 2'd1;
                    if (hphase_reg == 2'd2)
                    begin
                        state_reg <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        kind_reg <= KIND_HEAD_SPEED;
                        a_reg <= hx_reg;
                        b_reg <= hsat;
                    end
                end
                ST_STICK:
                    if (stick_done)
                    begin
                        state_reg <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        kind_reg <= KIND_BALL_MOVE;
                        a_reg <= stick_speed;
                        b_reg <= stick_dir;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        hp_reg <= hprod;
        if (state_reg == ST_HEAD && hphase_reg == 2'd1)
            hx_reg <= hsat;
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value_a))
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready)
    `ASSERT_IMPL(a_dir_range, clk, rst_n, out_valid && result_kind == KIND_BALL_MOVE,
        value_b >= 0 && value_b < 360)
endmodule

@@ bench/tb.sv @@
// Self-checking bench for gamepad_event_to_drive_commands_unit: directed table, then random
// phases, results compared against an in-bench predictor. Depends on gedc_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
    import gedc_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] a;
        logic [19:0] b;
    } drive_cmd_t;

    typedef enum int { ROW_PREDICT, ROW_TYPED, ROW_NONE } row_mode_t;

    typedef struct {
        logic [7:0]  cmd;
        logic [7:0]  num;
        logic [15:0] val;
        row_mode_t   mode;
        drive_cmd_t  res;
    } event_row_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  command = '0;
    logic [7:0]  event_number = '0;
    logic signed [15:0] event_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic signed [19:0] value_a;
    logic signed [19:0] value_b;

    gamepad_event_to_drive_commands_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .event_number(event_number), .event_value(event_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .value_a(value_a), .value_b(value_b)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [19:0]        ball_gain_q, head_gain_q;
    logic signed [15:0] btn_gain_q;
    logic [31:0]        btn_map_q, axis_map_q;
    logic signed [15:0] axes_q [4];
    bit                 btns_q [4];

    drive_cmd_t pending_cmds [$];
    int  errors = 0;
    int  n_events = 0;
    int  n_results = 0;
    int  cycles = 0;
    int  burst_left = 0;

    longint atan_tbl [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint heading(input longint x, input longint y);
        longint cx, cy, z, t, dx, dy, th;
        if (x == 0) return (y < 0) ? 0 : 180;
        cx = y * 16384;
        cy = x * 16384;
        z = 0;
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                t = cx; cx = cy; cy = -t; z = 90 * 65536;
            end
            else
            begin
                t = cx; cx = -cy; cy = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < 20; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx += dx; cy -= dy; z += atan_tbl[i];
            end
            else
            begin
                cx -= dx; cy += dy; z -= atan_tbl[i];
            end
        end
        th = 180 * 65536 - z;
        if (th < 0) th = 0;
        if (th > 360 * 65536 - 1) th = 360 * 65536 - 1;
        return th >>> 16;
    endfunction

    function automatic longint head_rate(input longint ax);
        longint p, q;
        p = ax * longint'(head_gain_q);
        q = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
        return (q > 50) ? 50 : q;
    endfunction

    function automatic int slot_of(input logic [31:0] map, input logic [7:0] n);
        for (int k = 0; k < 4; k++)
            if (map[8*k +: 8] == n) return k;
        return -1;
    endfunction

    function automatic bit predict_drive(input logic [7:0] c, input logic [7:0] n,
                                         input logic [15:0] v, output drive_cmd_t r);
        int k;
        longint d, x, y, sp;
        longint unsigned mag;
        r = '0;
        if (c == CMD_BUTTON)
        begin
            k = slot_of(btn_map_q, n);
            if (k < 0) return 0;
            btns_q[k] = (v != 0);
            if (k < 2)
            begin
                d = (longint'(btns_q[1]) - longint'(btns_q[0])) * longint'(btn_gain_q);
                r.kind = KIND_BALL_ROT;
            end
            else
            begin
                d = (longint'(btns_q[3]) - longint'(btns_q[2])) * longint'(btn_gain_q);
                if (d > 45) d = 45;
                r.kind = KIND_HEAD_ROT;
            end
            r.a = d[19:0];
            return 1;
        end
        if (c == CMD_AXIS)
        begin
            k = slot_of(axis_map_q, n);
            if (k < 0) return 0;
            axes_q[k] = v;
            if (k < 2)
            begin
                x = axes_q[0];
                y = axes_q[1];
                mag = root64(longint'(x * x + y * y) << 16);
                sp = longint'((mag * longint'(ball_gain_q)) >> 24);
                if (sp > 400) sp = 400;
                r.kind = KIND_BALL_MOVE;
                r.a = sp[19:0];
                d = heading(x, y);
                r.b = d[19:0];
            end
            else
            begin
                r.kind = KIND_HEAD_SPEED;
                d = head_rate(axes_q[2]);
                r.a = d[19:0];
                d = head_rate(axes_q[3]);
                r.b = d[19:0];
            end
            return 1;
        end
        return 0;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_BALL_GAIN:   ball_gain_q = data[19:0];
            REG_HEAD_GAIN:   head_gain_q = data[19:0];
            REG_BUTTON_GAIN: btn_gain_q = data[15:0];
            REG_BUTTON_MAP:  btn_map_q = data;
            REG_AXIS_MAP:    axis_map_q = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
        burst_left = 0;
    endtask

    task automatic set_config(input logic [19:0] bg, input logic [19:0] hg,
                              input logic [15:0] btg, input logic [31:0] bm,
                              input logic [31:0] am);
        wait_idle();
        write_reg(REG_BALL_GAIN, {12'(~0), bg});
        write_reg(REG_HEAD_GAIN, {12'h0, hg});
        write_reg(REG_BUTTON_GAIN, {16'hFFFF, btg});
        write_reg(REG_BUTTON_MAP, bm);
        write_reg(REG_AXIS_MAP, am);
    endtask

    task automatic send_event(input event_row_t row);
        drive_cmd_t r;
        bit has;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        command = row.cmd;
        event_number = row.num;
        event_value = row.val;
        in_valid = 1'b1;
        burst_left--;
        do @(posedge clk); while (!in_ready);
        n_events++;
        has = predict_drive(row.cmd, row.num, row.val, r);
        if (row.mode == ROW_TYPED) pending_cmds.push_back(row.res);
        else if (row.mode == ROW_PREDICT && has) pending_cmds.push_back(r);
    endtask

    // receiver stall pattern: steps through always ready, random, sparse random and periodic out_ready
    always @(negedge clk)
    begin
        case ((cycles / 64) % 4)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 1) == 1);
            2: out_ready = ($urandom_range(0, 3) == 0);
            default: out_ready = ((cycles % 7) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        drive_cmd_t e;
        int db;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected transaction kind=%0d a=%0d b=%0d",
                       result_kind, value_a, value_b);
                errors++;
            end
            else
            begin
                e = pending_cmds.pop_front();
                n_results++;
                if (result_kind !== e.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", e.kind, result_kind);
                    errors++;
                end
                if (value_a !== e.a)
                begin
                    $error("value_a: expected %0d, actual %0d", $signed(e.a), value_a);
                    errors++;
                end
                db = int'(value_b) - int'($signed(e.b));
                if ((^value_b === 1'bx) ||
                    (e.kind == KIND_BALL_MOVE ? (db > 1 || db < -1) : (db != 0)))
                begin
                    $error("value_b: expected %0d, actual %0d", $signed(e.b), value_b);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_map();
        logic [31:0] m;
        m = $urandom;
        if ($urandom_range(0, 3) == 0) m[8*$urandom_range(1, 3) +: 8] = m[7:0];
        return m;
    endfunction

    event_row_t dir_rows [] = '{
        '{CMD_BUTTON, 8'd0, 16'd1,     ROW_TYPED, '{KIND_BALL_ROT, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd0, 16'd0,     ROW_TYPED, '{KIND_BALL_MOVE, 20'd0, 20'd180}},
        '{CMD_AXIS,   8'd5, 16'd100,   ROW_NONE,  '{2'd0, 20'd0, 20'd0}},
        '{8'd0,       8'd0, 16'hFFFF,  ROW_NONE,  '{2'd0, 20'd0, 20'd0}},
        '{8'd255,     8'd0, 16'h7FFF,  ROW_NONE,  '{2'd0, 20'd0, 20'd0}},
        '{8'd3,       8'd1, 16'h8000,  ROW_NONE,  '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd0, 16'h8000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        // below: after the directed configuration is loaded
        '{CMD_BUTTON, 8'd2, 16'd1,     ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_BUTTON, 8'd1, 16'h8000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_BUTTON, 8'd1, 16'd0,     ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_BUTTON, 8'd3, 16'hFFFF,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_BUTTON, 8'd3, 16'd0,     ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_BUTTON, 8'd9, 16'd1,     ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd0, 16'h7FFF,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd1, 16'h8000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd1, 16'h7FFF,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd0, 16'h0000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd1, 16'hFFFB,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd0, 16'h8000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd2, 16'h7FFF,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd3, 16'h8000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd2, 16'h0000,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{CMD_AXIS,   8'd9, 16'h1234,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}},
        '{8'd2,       8'd3, 16'hFFFF,  ROW_PREDICT, '{2'd0, 20'd0, 20'd0}}
    };

    initial
    begin
        event_row_t row;
        logic [31:0] bm, am;
        ball_gain_q = '0; head_gain_q = '0; btn_gain_q = '0;
        btn_map_q = '0; axis_map_q = '0;
        for (int k = 0; k < 4; k++)
        begin
            axes_q[k] = '0;
            btns_q[k] = 1'b0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (i == 7)
            begin
                // right2 duplicates left1, so only left1 answers to number 1
                set_config(20'hFFFFF, 20'hFFFFF, 16'h8000, 32'h01030201, 32'h03020100);
                write_reg(3'd5, 32'hFFFFFFFF);
                write_reg(3'd7, 32'h0);
            end
            send_event(dir_rows[i]);
        end

        for (int p = 0; p < 6; p++)
        begin
            bm = pick_map();
            am = pick_map();
            case (p)
                0: set_config(20'hFFFFF, 20'hFFFFF, 16'h7FFF, bm, am);
                1: set_config(20'h0, 20'h0, 16'h0, bm, am);
                2: set_config(20'($urandom) >> $urandom_range(0, 8),
                              20'($urandom) >> $urandom_range(8, 19), 16'h8000, bm, am);
                default: set_config(20'($urandom) >> $urandom_range(0, 12),
                                    20'($urandom) >> $urandom_range(0, 19),
                                    16'($urandom), bm, am);
            endcase
            for (int j = 0; j < 150; j++)
            begin
                case ($urandom_range(0, 19))
                    0, 1: row.cmd = $urandom;
                    2, 3, 4, 5, 6, 7, 8, 9: row.cmd = CMD_BUTTON;
                    default: row.cmd = CMD_AXIS;
                endcase
                if ($urandom_range(0, 9) < 8)
                    row.num = (row.cmd == CMD_BUTTON) ? btn_map_q[8*$urandom_range(0, 3) +: 8]
                                                      : axis_map_q[8*$urandom_range(0, 3) +: 8];
                else
                    row.num = $urandom;
                row.val = pick_value();
                row.mode = ROW_PREDICT;
                row.res = '0;
                send_event(row);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d events and %0d drive commands over 8 register settings",
                 n_events, n_results);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
